// ===== rtl/core/nmea_gga_pkg.sv =====
// Package for the GGA sentence time extractor: parse phases, character codes,
// field limits and the small helper functions used by the core.
// No dependencies.
package nmea_gga_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [3:0] nibble_t;
  typedef logic [5:0] dial_t;

  typedef enum logic [3:0] {
    PH_HUNT   = 4'd0,
    PH_HDR1   = 4'd1,
    PH_HDR2   = 4'd2,
    PH_HDR3   = 4'd3,
    PH_HDR4   = 4'd4,
    PH_HDR5   = 4'd5,
    PH_COMMA  = 4'd6,
    PH_TIME   = 4'd7,
    PH_STAR   = 4'd8,
    PH_HEX_HI = 4'd9,
    PH_HEX_LO = 4'd10
  } phase_t;

  localparam byte_t CH_DOLLAR = 8'h24;
  localparam byte_t CH_G      = 8'h47;
  localparam byte_t CH_P      = 8'h50;
  localparam byte_t CH_A      = 8'h41;
  localparam byte_t CH_COMMA  = 8'h2C;
  localparam byte_t CH_STAR   = 8'h2A;
  localparam byte_t HEX_DIGIT_TOP = 8'h39;
  localparam byte_t HEX_ALPHA_BIAS = 8'h37;

  localparam int FIELD_MAX   = 16;
  localparam int TIME_DIGITS = 6;
  localparam int LONG_FIELD  = 7;
  localparam int HALF_DAY    = 12;
  localparam int DIAL_MAX    = 59;

  localparam logic [2:0] STEP_OF_QUARTER [16] = '{
    3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2,
    3'd2, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd0
  };

  function automatic byte_t header_char(phase_t ph);
    byte_t ch;
    unique case (ph)
      PH_HDR1: ch = CH_G;
      PH_HDR2: ch = CH_P;
      PH_HDR3: ch = CH_G;
      PH_HDR4: ch = CH_G;
      PH_HDR5: ch = CH_A;
      default: ch = CH_DOLLAR;
    endcase
    return ch;
  endfunction

  function automatic nibble_t hex_nibble(byte_t ch);
    byte_t adj;
    adj = (ch > HEX_DIGIT_TOP) ? ch - HEX_ALPHA_BIAS : ch;
    return adj[3:0];
  endfunction

endpackage

// ===== rtl/core/nmea_gga_time_extractor_unit.sv =====
// Top level of the GGA sentence time extractor: header match, XOR checksum,
// time field capture with 12-hour conversion, and the registered result stage.
// Depends on nmea_gga_pkg.
// The result register loads when its second checksum byte transfers.
// Throughput: one byte per cycle; bytes that end no sentence keep flowing while a
// result waits; the second checksum byte waits only while the result register is full.
// Reset: synchronous active-low rst_n; phase hunts for '$', all state but the result
// data registers zero, timezone offset 4.
module nmea_gga_time_extractor_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  nmea_gga_pkg::nibble_t cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  nmea_gga_pkg::byte_t   in_rx_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output nmea_gga_pkg::dial_t   out_hour_position,
  output nmea_gga_pkg::dial_t   out_minute_value,
  output nmea_gga_pkg::dial_t   out_second_value,
  output logic                  out_checksum_ok
);
  import nmea_gga_pkg::*;

  phase_t  phase_r, phase_nxt;
  logic [4:0] fofs_r, fofs_nxt;
  nibble_t digits_r [TIME_DIGITS];
  nibble_t digits_nxt [TIME_DIGITS];
  byte_t   xor_r, xor_nxt;
  byte_t   saved_xor_r, saved_xor_nxt;
  nibble_t rx_hi_r, rx_hi_nxt;
  dial_t   held_hour_r, held_hour_nxt;
  dial_t   held_min_r, held_min_nxt;
  dial_t   held_sec_r, held_sec_nxt;
  nibble_t tz_r;
  logic    out_valid_r, out_valid_nxt;
  dial_t   out_hour_r, out_min_r, out_sec_r;
  logic    out_ok_r;

  logic       accept, result_fire, ok;
  byte_t      h_raw, h_a, h_b, mn_raw, sc_raw;
  logic [8:0] h_diff;
  logic       tens_one;
  nibble_t    ones;
  dial_t      mn, sc, pos;
  logic [9:0] hr5;
  byte_t      rx_check;

  assign in_ready = !out_valid_r || out_ready || (phase_r != PH_HEX_LO);
  assign accept   = in_valid && in_ready;

  always_comb begin
    h_raw    = 8'(digits_r[0]) * 8'd10 + 8'(digits_r[1]);
    mn_raw   = 8'(digits_r[2]) * 8'd10 + 8'(digits_r[3]);
    sc_raw   = 8'(digits_r[4]) * 8'd10 + 8'(digits_r[5]);
    h_a      = (h_raw > 8'(HALF_DAY)) ? h_raw - 8'(HALF_DAY) : h_raw;
    h_b      = (h_a <= 8'(tz_r)) ? h_a + 8'(HALF_DAY) : h_a;
    h_diff   = {1'b0, h_b} - 9'(tz_r);
    tens_one = h_diff[8] || (h_diff[7:0] > 8'd9);
    ones     = tens_one ? 4'(h_diff - 9'd10) : h_diff[3:0];
    mn       = (mn_raw > 8'(DIAL_MAX)) ? 6'(DIAL_MAX) : mn_raw[5:0];
    sc       = (sc_raw > 8'(DIAL_MAX)) ? 6'(DIAL_MAX) : sc_raw[5:0];
    hr5      = 10'(h_raw) * 10'd5 + 10'(STEP_OF_QUARTER[mn[5:2]]);
    pos      = (hr5 > 10'(DIAL_MAX)) ? 6'd0 : hr5[5:0];
    rx_check = {rx_hi_r, hex_nibble(in_rx_byte)};
    ok       = (saved_xor_r == rx_check);
  end

  always_comb begin
    phase_nxt     = phase_r;
    fofs_nxt      = fofs_r;
    digits_nxt    = digits_r;
    xor_nxt       = xor_r;
    saved_xor_nxt = saved_xor_r;
    rx_hi_nxt     = rx_hi_r;
    held_hour_nxt = held_hour_r;
    held_min_nxt  = held_min_r;
    held_sec_nxt  = held_sec_r;
    result_fire   = 1'b0;
    if (accept) begin
      if (in_rx_byte != CH_STAR) begin
        xor_nxt = xor_r ^ in_rx_byte;
      end
      unique case (phase_r)
        PH_HDR1, PH_HDR2, PH_HDR3, PH_HDR4, PH_HDR5: begin
          phase_nxt = (in_rx_byte == header_char(phase_r)) ?
                      phase_t'(4'(phase_r) + 4'd1) : PH_HUNT;
        end
        PH_COMMA: begin
          fofs_nxt  = '0;
          phase_nxt = (in_rx_byte == CH_COMMA) ? PH_TIME : PH_HUNT;
        end
        PH_TIME: begin
          if (in_rx_byte == CH_COMMA) begin
            if (fofs_r > 5'(LONG_FIELD)) begin
              digits_nxt[0] = {3'd0, tens_one};
              digits_nxt[1] = ones;
            end
            fofs_nxt  = '0;
            phase_nxt = PH_STAR;
          end else if (fofs_r < 5'(FIELD_MAX)) begin
            if (fofs_r < 5'(TIME_DIGITS)) begin
              digits_nxt[fofs_r[2:0]] = in_rx_byte[3:0];
            end
            fofs_nxt = fofs_r + 5'd1;
          end
        end
        PH_STAR: begin
          if (in_rx_byte == CH_STAR) begin
            saved_xor_nxt = xor_r;
            phase_nxt     = PH_HEX_HI;
          end
        end
        PH_HEX_HI: begin
          rx_hi_nxt = hex_nibble(in_rx_byte);
          phase_nxt = PH_HEX_LO;
        end
        PH_HEX_LO: begin
          if (ok) begin
            held_hour_nxt = pos;
            held_min_nxt  = mn;
            held_sec_nxt  = sc;
          end
          for (int i = 0; i < TIME_DIGITS; i++) begin
            digits_nxt[i] = '0;
          end
          phase_nxt   = PH_HUNT;
          result_fire = 1'b1;
        end
        default: begin
          phase_nxt = (in_rx_byte == CH_DOLLAR) ? PH_HDR1 : PH_HUNT;
          xor_nxt   = '0;
        end
      endcase
    end
    out_valid_nxt = (out_valid_r && !out_ready) || result_fire;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      fofs_r      <= '0;
      for (int i = 0; i < TIME_DIGITS; i++) begin
        digits_r[i] <= '0;
      end
      xor_r       <= '0;
      saved_xor_r <= '0;
      rx_hi_r     <= '0;
      held_hour_r <= '0;
      held_min_r  <= '0;
      held_sec_r  <= '0;
      tz_r        <= 4'd4;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      fofs_r      <= fofs_nxt;
      digits_r    <= digits_nxt;
      xor_r       <= xor_nxt;
      saved_xor_r <= saved_xor_nxt;
      rx_hi_r     <= rx_hi_nxt;
      held_hour_r <= held_hour_nxt;
      held_min_r  <= held_min_nxt;
      held_sec_r  <= held_sec_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        tz_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (result_fire) begin
      out_hour_r <= held_hour_nxt;
      out_min_r  <= held_min_nxt;
      out_sec_r  <= held_sec_nxt;
      out_ok_r   <= ok;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hour_position = out_hour_r;
  assign out_minute_value  = out_min_r;
  assign out_second_value  = out_sec_r;
  assign out_checksum_ok   = out_ok_r;

endmodule

// ===== rtl/core/nmea_gga_checker.sv =====
// Port-level checker for the GGA sentence time extractor, bound to the top level.
// Depends on nmea_gga_pkg and nmea_gga_time_extractor_unit.
module nmea_gga_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  cfg_wr_en,
  input nmea_gga_pkg::nibble_t cfg_wr_data,
  input logic                  in_valid,
  input logic                  in_ready,
  input nmea_gga_pkg::byte_t   in_rx_byte,
  input logic                  out_valid,
  input logic                  out_ready,
  input nmea_gga_pkg::dial_t   out_hour_position,
  input nmea_gga_pkg::dial_t   out_minute_value,
  input nmea_gga_pkg::dial_t   out_second_value,
  input logic                  out_checksum_ok
);
  import nmea_gga_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hour_position) &&
    $stable(out_minute_value) && $stable(out_second_value) && $stable(out_checksum_ok))
    else $error("result changed while stalled");

  a_dial_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hour_position <= 6'(DIAL_MAX) && out_minute_value <= 6'(DIAL_MAX) &&
    out_second_value <= 6'(DIAL_MAX))
    else $error("dial value above range");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind nmea_gga_time_extractor_unit nmea_gga_checker u_nmea_gga_checker (.*);

// ===== dv/tb_nmea_gga_time_extractor_unit.sv =====
// Testbench for nmea_gga_time_extractor_unit: streams GGA sentences, broken
// sentences and line noise under several time-zone settings and checks every
// clock reading in order. Depends on nmea_gga_pkg and the unit RTL.
`timescale 1ns / 100ps

import nmea_gga_pkg::*;

typedef struct packed {
  dial_t hour_position;
  dial_t minute_value;
  dial_t second_value;
  logic  checksum_ok;
} clock_reading_t;

class gga_time_scoreboard;
  phase_t         phase;
  logic [4:0]     offset;
  nibble_t        digits [6];
  byte_t          run_sum;
  byte_t          frozen_sum;
  byte_t          sent_sum;
  dial_t          hour_pos;
  dial_t          minute;
  dial_t          second;
  nibble_t        tz;
  clock_reading_t pending_readings [$];
  int             errors;
  int             checked;
  int             matched;

  function new();
    phase      = PH_HUNT;
    offset     = '0;
    foreach (digits[i]) digits[i] = '0;
    run_sum    = '0;
    frozen_sum = '0;
    sent_sum   = '0;
    hour_pos   = '0;
    minute     = '0;
    second     = '0;
    tz         = 4'd4;
    errors     = 0;
    checked    = 0;
    matched    = 0;
  endfunction

  function nibble_t hex_value(byte_t c);
    return c[3:0] - ((c > HEX_DIGIT_TOP) ? HEX_ALPHA_BIAS[3:0] : 4'h0);
  endfunction

  function void note_byte(byte_t c);
    int unsigned    h;
    int unsigned    hr;
    int unsigned    mn;
    int unsigned    sc;
    byte_t          want;
    bit             ok;
    clock_reading_t r;
    if (c != CH_STAR) run_sum ^= c;
    case (phase)
      PH_HDR1, PH_HDR2, PH_HDR3, PH_HDR4, PH_HDR5: begin
        want  = (phase == PH_HDR2) ? CH_P : (phase == PH_HDR5) ? CH_A : CH_G;
        phase = (c == want) ? phase_t'(phase + 1) : PH_HUNT;
      end
      PH_COMMA: begin
        offset = '0;
        phase  = (c == CH_COMMA) ? PH_TIME : PH_HUNT;
      end
      PH_TIME: begin
        if (c == CH_COMMA) begin
          if (offset > LONG_FIELD) begin
            h = digits[0] * 10 + digits[1];
            if (h > HALF_DAY) h -= HALF_DAY;
            if (h <= tz) h += HALF_DAY;
            h -= tz;
            if (h > 9) begin
              digits[0] = 4'd1;
              h -= 10;
            end else begin
              digits[0] = 4'd0;
            end
            digits[1] = nibble_t'(h);
          end
          offset = '0;
          phase  = PH_STAR;
        end else if (offset < FIELD_MAX) begin
          if (offset < TIME_DIGITS) digits[offset] = c[3:0];
          offset++;
        end
      end
      PH_STAR: begin
        if (c == CH_STAR) begin
          frozen_sum = run_sum;
          phase      = PH_HEX_HI;
        end
      end
      PH_HEX_HI: begin
        sent_sum = {hex_value(c), 4'h0};
        phase    = PH_HEX_LO;
      end
      PH_HEX_LO: begin
        sent_sum[3:0] = hex_value(c);
        ok = (frozen_sum == sent_sum);
        if (ok) begin
          hr = digits[0] * 10 + digits[1];
          mn = digits[2] * 10 + digits[3];
          sc = digits[4] * 10 + digits[5];
          if (sc > DIAL_MAX) sc = DIAL_MAX;
          if (mn > DIAL_MAX) mn = DIAL_MAX;
          hr = hr * 5 + STEP_OF_QUARTER[(mn >> 2) & 15];
          if (hr > DIAL_MAX) hr = 0;
          hour_pos = dial_t'(hr);
          minute   = dial_t'(mn);
          second   = dial_t'(sc);
        end
        foreach (digits[i]) digits[i] = '0;
        phase = PH_HUNT;
        r = '{hour_pos, minute, second, ok};
        pending_readings.push_back(r);
      end
      default: begin
        phase   = (c == CH_DOLLAR) ? PH_HDR1 : PH_HUNT;
        run_sum = '0;
      end
    endcase
  endfunction

  function void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  function void check_reading(clock_reading_t got);
    clock_reading_t want;
    if (pending_readings.size() == 0) begin
      $error("reading with none expected: hour %0d minute %0d second %0d ok %0b",
             got.hour_position, got.minute_value, got.second_value, got.checksum_ok);
      errors++;
      return;
    end
    want = pending_readings.pop_front();
    checked++;
    if (want.checksum_ok) matched++;
    compare_field("hour_position", want.hour_position, got.hour_position);
    compare_field("minute_value", want.minute_value, got.minute_value);
    compare_field("second_value", want.second_value, got.second_value);
    compare_field("checksum_ok", want.checksum_ok, got.checksum_ok);
  endfunction
endclass

module tb_nmea_gga_time_extractor_unit;

  localparam byte_t CH_ZERO      = 8'h30;
  localparam byte_t CH_DOT       = 8'h2E;
  localparam byte_t CH_LOWER_A   = 8'h61;
  localparam byte_t CH_CR        = 8'h0D;
  localparam byte_t CH_LF        = 8'h0A;
  localparam int    TAIL_CYCLES  = 4;
  localparam int    PHASES       = 5;
  localparam int    PHASE_BYTES  = 260;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    cfg_wr_en = 1'b0;
  nibble_t cfg_wr_data = '0;
  logic    in_valid = 1'b0;
  logic    in_ready;
  byte_t   in_rx_byte = '0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  dial_t   out_hour_position;
  dial_t   out_minute_value;
  dial_t   out_second_value;
  logic    out_checksum_ok;

  gga_time_scoreboard sb;
  byte_t sentence_bytes [$];
  byte_t fold_sum;
  int    tx_idle_pct = 25;
  int    rx_idle_pct = 25;
  int    sentences_sent = 0;
  int    bytes_sent = 0;

  nmea_gga_time_extractor_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_hour_position (out_hour_position),
    .out_minute_value  (out_minute_value),
    .out_second_value  (out_second_value),
    .out_checksum_ok   (out_checksum_ok)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("watchdog expired with %0d readings outstanding",
             sb.pending_readings.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int pick_gap(int pct);
    int r;
    if ($urandom_range(0, 99) >= pct) return 0;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  function automatic void put_byte(byte_t b);
    sentence_bytes.push_back(b);
    if (b != CH_STAR) fold_sum ^= b;
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endfunction

  function automatic void put_digits(int v);
    put_byte(byte_t'(CH_ZERO + v / 10));
    put_byte(byte_t'(CH_ZERO + v % 10));
  endfunction

  function automatic byte_t hex_char(nibble_t n);
    if (n < 10) return CH_ZERO + n;
    return byte_t'((($urandom_range(0, 3) == 0) ? CH_LOWER_A : CH_A) + n - 10);
  endfunction

  function automatic void start_sentence();
    sentence_bytes = {CH_DOLLAR};
    fold_sum = '0;
    put_text("GPGGA,");
  endfunction

  function automatic void close_sentence(bit good, bit noisy);
    byte_t ck;
    put_byte(CH_STAR);
    ck = fold_sum ^ (good ? 8'h00 : byte_t'($urandom_range(1, 255)));
    if (noisy && $urandom_range(0, 19) == 0) begin
      put_byte(byte_t'($urandom_range(0, 255)));
      put_byte(byte_t'($urandom_range(0, 255)));
    end else begin
      put_byte(hex_char(ck[7:4]));
      put_byte(hex_char(ck[3:0]));
    end
    if (noisy && $urandom_range(0, 1)) begin
      put_byte(CH_CR);
      put_byte(CH_LF);
    end
  endfunction

  function automatic void build_sentence();
    int    kind;
    byte_t b;
    start_sentence();
    kind = $urandom_range(0, 9);
    if (kind < 5) begin
      put_digits($urandom_range(0, 23));
      put_digits($urandom_range(0, 59));
      put_digits($urandom_range(0, 59));
      put_byte(CH_DOT);
      repeat ($urandom_range(1, 3)) put_byte(byte_t'(CH_ZERO + $urandom_range(0, 9)));
    end else if (kind < 7) begin
      put_digits($urandom_range(0, 23));
      put_digits($urandom_range(0, 59));
      put_digits($urandom_range(0, 59));
      repeat ($urandom_range(0, 2)) put_byte(byte_t'(CH_ZERO + $urandom_range(0, 9)));
    end else if (kind < 8) begin
      put_digits($urandom_range(0, 99));
      put_digits($urandom_range(0, 99));
      put_digits($urandom_range(0, 99));
      if ($urandom_range(0, 1)) put_text(".00");
    end else begin
      repeat ($urandom_range(0, 20)) begin
        b = byte_t'($urandom_range(0, 255));
        put_byte((b == CH_COMMA) ? CH_DOT : b);
      end
    end
    put_byte(CH_COMMA);
    repeat ($urandom_range(0, 10)) begin
      b = byte_t'($urandom_range(0, 255));
      put_byte((b == CH_STAR) ? CH_COMMA : b);
    end
    close_sentence($urandom_range(0, 99) < 85, 1'b1);
  endfunction

  task automatic send_byte(byte_t b);
    int gap;
    gap = pick_gap(tx_idle_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_all();
    foreach (sentence_bytes[i]) send_byte(sentence_bytes[i]);
  endtask

  // hold the sender until every reading is out, then let the pipe settle
  task automatic drain_readings();
    in_valid <= 1'b0;
    while (sb.pending_readings.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic set_timezone(nibble_t v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.tz = v;
  endtask

  initial begin
    int gap;
    wait (rst_n);
    forever begin
      gap = pick_gap(rx_idle_pct);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_reading('{out_hour_position, out_minute_value, out_second_value,
                         out_checksum_ok});
  end

  initial begin
    nibble_t tz_plan [PHASES];
    int      tx_plan [PHASES];
    int      rx_plan [PHASES];
    int      phase_end;
    int      r;
    int      n;
    sb = new();
    tz_plan = '{4'd12, 4'd0, 4'd7, 4'd0, 4'd12};
    tz_plan[3] = nibble_t'($urandom_range(1, 11));
    tx_plan = '{25, 0, 40, 25, 60};
    rx_plan = '{25, 0, 20, 50, 35};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // header broken by a second dollar, then a long time field with clamped fields
    sentence_bytes = {CH_DOLLAR, CH_G, CH_P, CH_DOLLAR};
    send_all();
    start_sentence();
    put_text("129960.0,");
    close_sentence(1'b1, 1'b0);
    send_all();
    sentences_sent += 2;

    for (int p = 0; p < PHASES; p++) begin
      drain_readings();
      set_timezone(tz_plan[p]);
      tx_idle_pct = tx_plan[p];
      rx_idle_pct = rx_plan[p];
      phase_end = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_end) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          build_sentence();
          send_all();
          sentences_sent++;
        end else if (r < 85) begin
          build_sentence();
          n = $urandom_range(1, sentence_bytes.size() - 1);
          while (sentence_bytes.size() > n) void'(sentence_bytes.pop_back());
          if ($urandom_range(0, 1)) sentence_bytes[n - 1] = byte_t'($urandom_range(0, 255));
          send_all();
          sentences_sent++;
        end else begin
          sentence_bytes = {};
          repeat ($urandom_range(1, 8))
            sentence_bytes.push_back(byte_t'($urandom_range(0, 255)));
          send_all();
        end
      end
    end
    drain_readings();

    $display("Sent %0d bytes in %0d sentences over %0d time-zone settings.",
             bytes_sent, sentences_sent, PHASES);
    $display("Checked %0d readings, %0d of them with a matching checksum.",
             sb.checked, sb.matched);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
